@@ rtl/core/gbrd_pkg.sv @@
`timescale 1ns / 1ps

package gbrd_pkg;

    // Fixed field widths of the item and event formats.
    localparam int NUM_ANALOG     = 6;
    localparam int VALUE_W        = 16;
    localparam int SOURCE_W       = 4;
    localparam int SLOT_FIELD_W   = 2;
    localparam int BUTTON_FIELD_W = 14;
    localparam int DELAY_W        = 7;
    localparam int DZ_W           = 15;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 15;

    // Item modes.
    localparam logic [1:0] MODE_POLL       = 2'd0;
    localparam logic [1:0] MODE_CONNECT    = 2'd1;
    localparam logic [1:0] MODE_DISCONNECT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_DELAY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_DZ      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_DZ     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_DZ   = 2'd3;

    // Register values after reset.
    localparam logic [DELAY_W-1:0] RESET_REPEAT_DELAY = 7'd60;
    localparam logic [DZ_W-1:0]    RESET_LEFT_DZ      = 15'd7864;
    localparam logic [DZ_W-1:0]    RESET_RIGHT_DZ     = 15'd8847;
    localparam logic [DZ_W-1:0]    RESET_TRIGGER_DZ   = 15'd3932;

    // Analog limits in Q1.15.
    localparam logic signed [VALUE_W-1:0] VALUE_NEG_FULL = 16'sh8000;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN      = -16'sd32767;

    typedef enum logic [1:0] {
        EV_DOWN   = 2'd0,
        EV_REPEAT = 2'd1,
        EV_UP     = 2'd2,
        EV_ANALOG = 2'd3
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t                    kind;
        logic [SOURCE_W-1:0]         source;
        logic [SLOT_FIELD_W-1:0]     slot;
        logic signed [VALUE_W-1:0]   value;
    } event_t;

    // Request from the sequencer to the event buffer.
    typedef struct packed {
        logic   push;
        logic   flush;
        event_t ev;
    } evq_req_t;

endpackage

@@ rtl/core/gamepad_button_repeat_deadzone_core.sv @@
`timescale 1ns / 1ps

// Gamepad button auto-repeat and analog dead-zone event generator. Items are taken one
// at a time. A poll of a connected slot walks its buttons and then its six analog
// channels, one state-memory entry per cycle in a read-modify-write loop while the
// output is not stalled; a disconnect walks only the buttons. A connect of a free slot
// sweeps that slot's memory entries to zero, one per cycle. A slot's entries are only
// read after its connect has cleared them, so no clearing pass runs after reset. Events
// come out one per transfer, the last one of an item marked by last; a stalled output
// holds the walk while the pending event waits.
module gamepad_button_repeat_deadzone_core #(
    parameter int NUM_SLOTS   = 4,
    parameter int NUM_BUTTONS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [14:0]          cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [1:0]           slot,
    input  logic [13:0]          pressed_buttons,
    input  logic signed [15:0]   right_trigger,
    input  logic signed [15:0]   left_trigger,
    input  logic signed [15:0]   right_stick_x,
    input  logic signed [15:0]   right_stick_y,
    input  logic signed [15:0]   left_stick_x,
    input  logic signed [15:0]   left_stick_y,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           event_kind,
    output logic [3:0]           source,
    output logic [1:0]           event_slot,
    output logic signed [15:0]   analog_value,
    output logic                 last
);

    localparam int NUM_ANALOG  = gbrd_pkg::NUM_ANALOG;
    localparam int DELAY_W     = gbrd_pkg::DELAY_W;
    localparam int DZ_W        = gbrd_pkg::DZ_W;
    localparam int VALUE_W     = gbrd_pkg::VALUE_W;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int ANA_IDX_W   = $clog2(NUM_ANALOG);
    localparam int STEPS_MAX   = NUM_BUTTONS + NUM_ANALOG;
    localparam int STEP_W      = $clog2(STEPS_MAX + 1);
    localparam int CLEAR_LEN   = (NUM_BUTTONS > NUM_ANALOG) ? NUM_BUTTONS : NUM_ANALOG;
    localparam int BTN_DEPTH   = NUM_SLOTS * NUM_BUTTONS;
    localparam int BTN_AW      = (BTN_DEPTH > 1) ? $clog2(BTN_DEPTH) : 1;
    localparam int ANA_DEPTH   = NUM_SLOTS * NUM_ANALOG;
    localparam int ANA_AW      = $clog2(ANA_DEPTH);
    localparam int BTN_ENTRY_W = 1 + DELAY_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RUN,
        ST_FIN
    } state_t;

    // Limit -1.0, the one Q1.15 value without a positive counterpart, to the symmetric minimum.
    function automatic logic signed [VALUE_W-1:0] sat_q15(input logic signed [VALUE_W-1:0] v);
        logic signed [VALUE_W-1:0] r;
        r = (v == gbrd_pkg::VALUE_NEG_FULL) ? gbrd_pkg::VALUE_MIN : v;
        return r;
    endfunction

    state_t                      state_reg;
    logic                        is_poll_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        v2_reg;
    logic [STEP_W-1:0]           j2_reg;
    logic [NUM_SLOTS-1:0]        connected_reg;
    logic [DELAY_W-1:0]          repeat_delay_reg;
    logic [DZ_W-1:0]             left_dz_reg;
    logic [DZ_W-1:0]             right_dz_reg;
    logic [DZ_W-1:0]             trigger_dz_reg;

    logic [1:0]                  slot_reg;
    logic [NUM_BUTTONS-1:0]      btn_bits_reg;
    logic signed [VALUE_W-1:0]   analog_reg [NUM_ANALOG];

    logic                        in_xfer;
    logic                        slot_ok;
    logic [SLOT_W-1:0]           in_slot_idx;
    logic [SLOT_W-1:0]           cur_slot;
    logic [STEP_W-1:0]           step_total;
    logic                        ev_ready;
    logic                        issue;
    logic                        proc;
    gbrd_pkg::evq_req_t          ev_req;

    logic                        btn_we;
    logic                        btn_re;
    logic [BTN_AW-1:0]           btn_waddr;
    logic [BTN_AW-1:0]           btn_raddr;
    logic [BTN_ENTRY_W-1:0]      btn_wdata;
    logic [BTN_ENTRY_W-1:0]      btn_rdata;
    logic                        ana_we;
    logic                        ana_re;
    logic [ANA_AW-1:0]           ana_waddr;
    logic [ANA_AW-1:0]           ana_raddr;
    logic signed [VALUE_W-1:0]   ana_wdata;
    logic signed [VALUE_W-1:0]   ana_rdata;

    logic                        j2_is_btn;
    logic [BTN_IDX_W-1:0]        btn_k;
    logic [ANA_IDX_W-1:0]        ana_k;
    logic                        now_pressed;
    logic                        held;
    logic [DELAY_W-1:0]          cnt;
    logic [DELAY_W:0]            cnt_inc;
    logic signed [VALUE_W-1:0]   ana_v;
    logic signed [VALUE_W-1:0]   ana_neg;
    logic [DZ_W-1:0]             ana_mag;
    logic [DZ_W-1:0]             ana_dz;
    logic [STEP_W-1:0]           wr_step;
    int                          ana_wpos;

    gbrd_pkg::event_t            out_ev;

    // Input handshake and slot decode.
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign slot_ok     = (int'(slot) < NUM_SLOTS);
    assign in_slot_idx = SLOT_W'(slot);
    assign cur_slot    = SLOT_W'(slot_reg);
    assign step_total  = is_poll_reg ? STEP_W'(STEPS_MAX) : STEP_W'(NUM_BUTTONS);

    // Read issue stage and process stage of the memory walk.
    assign issue  = (state_reg == ST_RUN) && ev_ready && (step_reg < step_total);
    assign proc   = (state_reg == ST_RUN) && ev_ready && v2_reg;
    assign btn_re = issue && (int'(step_reg) < NUM_BUTTONS);
    assign ana_re = issue && (int'(step_reg) >= NUM_BUTTONS);
    assign btn_raddr = BTN_AW'(int'(cur_slot) * NUM_BUTTONS + int'(step_reg));
    assign ana_raddr = ANA_AW'(int'(cur_slot) * NUM_ANALOG + int'(step_reg) - NUM_BUTTONS);

    // Fields of the entry being processed.
    assign j2_is_btn   = (int'(j2_reg) < NUM_BUTTONS);
    assign btn_k       = BTN_IDX_W'(j2_reg);
    assign ana_k       = ANA_IDX_W'(j2_reg - STEP_W'(NUM_BUTTONS));
    assign now_pressed = btn_bits_reg[btn_k];
    assign held        = btn_rdata[DELAY_W];
    assign cnt         = btn_rdata[DELAY_W-1:0];
    assign cnt_inc     = {1'b0, cnt} + {{DELAY_W{1'b0}}, 1'b1};
    assign ana_v       = analog_reg[ana_k];
    assign ana_neg     = -ana_v;
    assign ana_mag     = ana_v[VALUE_W-1] ? ana_neg[DZ_W-1:0] : ana_v[DZ_W-1:0];

    // Dead zone per channel: triggers, right stick, left stick.
    always_comb
    begin
        case (ana_k)
            3'd0, 3'd1: ana_dz = trigger_dz_reg;
            3'd2, 3'd3: ana_dz = right_dz_reg;
            default:    ana_dz = left_dz_reg;
        endcase
    end

    // Write-back addresses: the sweep position while clearing, else the processed entry.
    assign wr_step   = (state_reg == ST_CLEAR) ? step_reg : j2_reg;
    assign ana_wpos  = (state_reg == ST_CLEAR) ? int'(step_reg) : int'(ana_k);
    assign btn_waddr = BTN_AW'(int'(cur_slot) * NUM_BUTTONS + int'(wr_step));
    assign ana_waddr = ANA_AW'(int'(cur_slot) * NUM_ANALOG + ana_wpos);

    // Event generation and memory write-back for one entry, the clearing sweep and the item-end flush.
    always_comb
    begin
        ev_req           = '0;
        ev_req.ev.slot   = slot_reg;
        ev_req.flush     = (state_reg == ST_FIN);
        btn_we           = 1'b0;
        btn_wdata        = btn_rdata;
        ana_we           = 1'b0;
        ana_wdata        = ana_v;
        if (state_reg == ST_CLEAR)
        begin
            btn_we    = (int'(step_reg) < NUM_BUTTONS);
            btn_wdata = '0;
            ana_we    = (int'(step_reg) < NUM_ANALOG);
            ana_wdata = '0;
        end
        else if (proc)
        begin
            if (j2_is_btn)
            begin
                ev_req.ev.source = gbrd_pkg::SOURCE_W'(j2_reg + STEP_W'(1));
                if (is_poll_reg)
                begin
                    btn_we = 1'b1;
                    if (now_pressed && held)
                    begin
                        if (cnt_inc >= {1'b0, repeat_delay_reg})
                        begin
                            ev_req.push    = 1'b1;
                            ev_req.ev.kind = gbrd_pkg::EV_REPEAT;
                            btn_wdata      = {1'b1, repeat_delay_reg};
                        end
                        else
                        begin
                            btn_wdata = {1'b1, cnt_inc[DELAY_W-1:0]};
                        end
                    end
                    else if (now_pressed)
                    begin
                        ev_req.push    = 1'b1;
                        ev_req.ev.kind = gbrd_pkg::EV_DOWN;
                        btn_wdata      = {1'b1, DELAY_W'(1)};
                    end
                    else if (held)
                    begin
                        ev_req.push    = 1'b1;
                        ev_req.ev.kind = gbrd_pkg::EV_UP;
                        btn_wdata      = '0;
                    end
                    else
                    begin
                        btn_wdata = {1'b0, cnt};
                    end
                end
                else if (held)
                begin
                    // Disconnect releases every held button; connect clears later.
                    ev_req.push    = 1'b1;
                    ev_req.ev.kind = gbrd_pkg::EV_UP;
                end
            end
            else if (is_poll_reg)
            begin
                ana_we           = 1'b1;
                ev_req.ev.source = gbrd_pkg::SOURCE_W'(ana_k);
                if ((ana_v != ana_rdata) || (ana_mag > ana_dz))
                begin
                    ev_req.push     = 1'b1;
                    ev_req.ev.kind  = gbrd_pkg::EV_ANALOG;
                    ev_req.ev.value = ana_v;
                end
            end
        end
    end

    // Sequencer, slot flags and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            is_poll_reg      <= 1'b0;
            step_reg         <= '0;
            v2_reg           <= 1'b0;
            j2_reg           <= '0;
            connected_reg    <= '0;
            repeat_delay_reg <= gbrd_pkg::RESET_REPEAT_DELAY;
            left_dz_reg      <= gbrd_pkg::RESET_LEFT_DZ;
            right_dz_reg     <= gbrd_pkg::RESET_RIGHT_DZ;
            trigger_dz_reg   <= gbrd_pkg::RESET_TRIGGER_DZ;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    gbrd_pkg::CFG_REPEAT_DELAY: repeat_delay_reg <= cfg_data[DELAY_W-1:0];
                    gbrd_pkg::CFG_LEFT_DZ:      left_dz_reg      <= cfg_data[DZ_W-1:0];
                    gbrd_pkg::CFG_RIGHT_DZ:     right_dz_reg     <= cfg_data[DZ_W-1:0];
                    gbrd_pkg::CFG_TRIGGER_DZ:   trigger_dz_reg   <= cfg_data[DZ_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        step_reg <= '0;
                        v2_reg   <= 1'b0;
                        if (slot_ok)
                        begin
                            case (mode)
                                gbrd_pkg::MODE_CONNECT:
                                begin
                                    if (!connected_reg[in_slot_idx])
                                    begin
                                        connected_reg[in_slot_idx] <= 1'b1;
                                        state_reg                  <= ST_CLEAR;
                                    end
                                end
                                gbrd_pkg::MODE_DISCONNECT:
                                begin
                                    if (connected_reg[in_slot_idx])
                                    begin
                                        connected_reg[in_slot_idx] <= 1'b0;
                                        is_poll_reg                <= 1'b0;
                                        state_reg                  <= ST_RUN;
                                    end
                                end
                                gbrd_pkg::MODE_POLL:
                                begin
                                    if (connected_reg[in_slot_idx])
                                    begin
                                        is_poll_reg <= 1'b1;
                                        state_reg   <= ST_RUN;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                ST_CLEAR:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(CLEAR_LEN - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RUN:
                begin
                    if (ev_ready)
                    begin
                        if (step_reg < step_total)
                        begin
                            step_reg <= step_reg + STEP_W'(1);
                            v2_reg   <= 1'b1;
                            j2_reg   <= step_reg;
                        end
                        else
                        begin
                            v2_reg    <= 1'b0;
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_FIN:
                begin
                    if (ev_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item payload captured on transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            slot_reg      <= slot;
            btn_bits_reg  <= NUM_BUTTONS'(pressed_buttons);
            analog_reg[0] <= sat_q15(right_trigger);
            analog_reg[1] <= sat_q15(left_trigger);
            analog_reg[2] <= sat_q15(right_stick_x);
            analog_reg[3] <= sat_q15(right_stick_y);
            analog_reg[4] <= sat_q15(left_stick_x);
            analog_reg[5] <= sat_q15(left_stick_y);
        end
    end

    // Held flag and repeat count per slot and button.
    gbrd_ram #(
        .WIDTH (BTN_ENTRY_W),
        .DEPTH (BTN_DEPTH)
    ) u_btn_mem (
        .clk   (clk),
        .we    (btn_we),
        .waddr (btn_waddr),
        .wdata (btn_wdata),
        .re    (btn_re),
        .raddr (btn_raddr),
        .rdata (btn_rdata)
    );

    // Previous analog value per slot and channel.
    gbrd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ANA_DEPTH)
    ) u_ana_mem (
        .clk   (clk),
        .we    (ana_we),
        .waddr (ana_waddr),
        .wdata (ana_wdata),
        .re    (ana_re),
        .raddr (ana_raddr),
        .rdata (ana_rdata)
    );

    gbrd_event_buf u_event_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (ev_req),
        .ready     (ev_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_ev    (out_ev),
        .out_last  (last)
    );

    assign event_kind   = out_ev.kind;
    assign source       = out_ev.source;
    assign event_slot   = out_ev.slot;
    assign analog_value = out_ev.value;

    // The walk never reads a button entry in the cycle it is written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (btn_we && btn_re) |-> (btn_waddr != btn_raddr))
        else $error("button memory read and write hit the same entry");

    // Nothing is left in the process stage once the item is being closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> !v2_reg)
        else $error("entry still in flight at item end");

    // Events are produced only by the memory walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_req.push |-> (state_reg == ST_RUN))
        else $error("event pushed outside the walk");

    // A poll walk only runs on a connected slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && is_poll_reg) |-> connected_reg[cur_slot])
        else $error("poll walk on a disconnected slot");

endmodule

@@ rtl/core/gbrd_ram.sv @@
`timescale 1ns / 1ps

module gbrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/gbrd_event_buf.sv @@
`timescale 1ns / 1ps

module gbrd_event_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  gbrd_pkg::evq_req_t req,
    output logic               ready,
    output logic               out_valid,
    input  logic               out_stall,
    output gbrd_pkg::event_t   out_ev,
    output logic               out_last
);

    logic              pend_valid_reg;
    logic              pend_valid_next;
    gbrd_pkg::event_t  pend_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    gbrd_pkg::event_t  out_reg;
    logic              out_last_reg;
    logic              out_free;
    logic              load_out;

    // The newest event waits in the pending stage until the next one arrives or
    // the item ends, so the final event can be marked before it leaves.
    assign out_free = !out_valid_reg || !out_stall;
    assign ready    = !pend_valid_reg || out_free;
    assign load_out = ready && pend_valid_reg && (req.push || req.flush);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (ready && req.push)
        begin
            pend_valid_next = 1'b1;
        end
        else if (ready && req.flush)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = load_out ? 1'b1 : (out_valid_reg && out_stall);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Event payloads.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= req.flush;
        end
        if (ready && req.push)
        begin
            pend_reg <= req.ev;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ev    = out_reg;
    assign out_last  = out_last_reg;

endmodule
